// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the header field line scanner RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HFLS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define HFLS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hfls_pkg.sv =====
// Shared types, constants and the byte classifier for the header field line scanner.
// No dependencies.
package hfls_pkg;

    localparam int DEF_MAX_BLOCK_BYTES = 65536;
    localparam int DEF_MAX_FIELDS      = 256;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_HT    = 8'h09;

    localparam logic [2:0] EV_READING   = 3'd0;
    localparam logic [2:0] EV_ADDED     = 3'd1;
    localparam logic [2:0] EV_EXTENDED  = 3'd2;
    localparam logic [2:0] EV_SEPARATOR = 3'd3;
    localparam logic [2:0] EV_ERROR     = 3'd4;

    typedef struct packed {
        logic cr;
        logic lf;
        logic colon;
        logic white;
    } hfls_class_t;

    // Fields from the lowest bit up: event_res, field_index, name_offset,
    // name_length, value_offset, value_length, zero pad.
    typedef struct packed {
        logic [4:0]  pad;
        logic [15:0] value_length;
        logic [15:0] value_offset;
        logic [15:0] name_length;
        logic [15:0] name_offset;
        logic [7:0]  field_index;
        logic [2:0]  event_res;
    } hfls_result_t;

    function automatic hfls_class_t hfls_classify(input logic [7:0] b);
        hfls_class_t c;
        c.cr    = (b == CHAR_CR);
        c.lf    = (b == CHAR_LF);
        c.colon = (b == CHAR_COLON);
        c.white = (b == CHAR_SPACE) || ((b >= CHAR_HT) && (b <= CHAR_CR));
        return c;
    endfunction

endpackage

// ===== rtl/hfls_front.sv =====
// Front end: accepts header bytes, classifies them and queues the classes.
// Depends on hfls_pkg and assert_macros.svh.
`include "assert_macros.svh"
module hfls_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    output logic                q_valid,
    output hfls_pkg::hfls_class_t q_class,
    input  logic                q_pop
);
    import hfls_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    hfls_class_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   push;
    logic                   pop;

    assign in_ready = (count_reg < CNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_class  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= hfls_classify(in_byte);
        end
    end

    `HFLS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
    `HFLS_ASSERT_IMP(a_pop_nonempty, q_pop, count_reg != '0, "pop from empty queue")
    `HFLS_ASSERT_NXT(a_push_counts, push && !pop, count_reg == $past(count_reg) + 1'b1,
                     "push lost")

endmodule

// ===== rtl/hfls_back.sv =====
// Back end: line scanner state, field bookkeeping and the result register.
// Depends on hfls_pkg and assert_macros.svh.
`include "assert_macros.svh"
module hfls_back #(
    parameter int MAX_BLOCK_BYTES = hfls_pkg::DEF_MAX_BLOCK_BYTES,
    parameter int MAX_FIELDS      = hfls_pkg::DEF_MAX_FIELDS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  hfls_pkg::hfls_class_t  q_class,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output hfls_pkg::hfls_result_t out_data
);
    import hfls_pkg::*;

    localparam int PW = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int CW = $clog2(MAX_FIELDS + 1);

    localparam logic [1:0] PH_LINE_START = 2'd0;
    localparam logic [1:0] PH_IN_LINE    = 2'd1;
    localparam logic [1:0] PH_AFTER_CR   = 2'd2;
    localparam logic [1:0] PH_ERROR      = 2'd3;

    logic [1:0]    phase_reg, phase_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] line_begin_reg, line_begin_next;
    logic [PW-1:0] colon_pos_reg, colon_pos_next;
    logic          colon_seen_reg, colon_seen_next;
    logic          cont_reg, cont_next;
    logic [CW-1:0] fc_reg, fc_next;
    logic [PW-1:0] last_voff_reg, last_voff_next;
    logic [PW-1:0] last_noff_reg, last_noff_next;
    logic [PW-1:0] last_nlen_reg, last_nlen_next;
    logic          out_valid_reg, out_valid_next;
    hfls_result_t  out_reg, out_next;

    logic          take;
    logic [PW-1:0] pos_inc;
    logic [PW-1:0] voff_new;
    logic          eff_cont;
    logic          eff_seen;
    hfls_result_t  res;

    assign take     = q_valid && (!out_valid_reg || out_ready);
    assign q_pop    = take;
    assign pos_inc  = pos_reg + PW'(1);
    assign voff_new = colon_pos_reg + PW'(1);

    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        line_begin_next = line_begin_reg;
        colon_pos_next  = colon_pos_reg;
        colon_seen_next = colon_seen_reg;
        cont_next       = cont_reg;
        fc_next         = fc_reg;
        last_voff_next  = last_voff_reg;
        last_noff_next  = last_noff_reg;
        last_nlen_next  = last_nlen_reg;
        eff_cont        = cont_reg;
        eff_seen        = colon_seen_reg;
        res             = '0;
        res.event_res   = EV_READING;

        if (take)
        begin
            if (phase_reg == PH_ERROR)
            begin
                res.event_res = EV_ERROR;
            end
            else if (pos_reg >= PW'(MAX_BLOCK_BYTES))
            begin
                phase_next    = PH_ERROR;
                res.event_res = EV_ERROR;
            end
            else if (phase_reg == PH_AFTER_CR)
            begin
                if (!q_class.lf)
                begin
                    phase_next    = PH_ERROR;
                    res.event_res = EV_ERROR;
                end
                else if ((pos_reg - line_begin_reg) == PW'(1))
                begin
                    // empty line: separator, restart the block
                    phase_next      = PH_LINE_START;
                    pos_next        = '0;
                    line_begin_next = '0;
                    colon_pos_next  = '0;
                    colon_seen_next = 1'b0;
                    cont_next       = 1'b0;
                    fc_next         = '0;
                    last_voff_next  = '0;
                    last_noff_next  = '0;
                    last_nlen_next  = '0;
                    res.event_res   = EV_SEPARATOR;
                end
                else
                begin
                    pos_next   = pos_inc;
                    phase_next = PH_LINE_START;
                    if (cont_reg)
                    begin
                        if (fc_reg == '0)
                        begin
                            phase_next    = PH_ERROR;
                            res.event_res = EV_ERROR;
                        end
                        else
                        begin
                            res.event_res    = EV_EXTENDED;
                            res.field_index  = 8'(fc_reg - CW'(1));
                            res.name_offset  = 16'(last_noff_reg);
                            res.name_length  = 16'(last_nlen_reg);
                            res.value_offset = 16'(last_voff_reg);
                            res.value_length = 16'(pos_inc - last_voff_reg);
                        end
                    end
                    else if (!colon_seen_reg || (fc_reg >= CW'(MAX_FIELDS)))
                    begin
                        phase_next    = PH_ERROR;
                        res.event_res = EV_ERROR;
                    end
                    else
                    begin
                        last_noff_next   = line_begin_reg;
                        last_nlen_next   = colon_pos_reg - line_begin_reg;
                        last_voff_next   = voff_new;
                        fc_next          = fc_reg + CW'(1);
                        res.event_res    = EV_ADDED;
                        res.field_index  = 8'(fc_reg);
                        res.name_offset  = 16'(line_begin_reg);
                        res.name_length  = 16'(colon_pos_reg - line_begin_reg);
                        res.value_offset = 16'(voff_new);
                        res.value_length = 16'(pos_inc - voff_new);
                    end
                end
            end
            else
            begin
                if (phase_reg == PH_LINE_START)
                begin
                    line_begin_next = pos_reg;
                    colon_seen_next = 1'b0;
                    colon_pos_next  = '0;
                    cont_next       = q_class.white;
                    eff_cont        = q_class.white;
                    eff_seen        = 1'b0;
                end
                if (q_class.cr)
                begin
                    phase_next = PH_AFTER_CR;
                end
                else
                begin
                    phase_next = PH_IN_LINE;
                    // only the first colon of a field line counts
                    if (q_class.colon && !eff_cont && !eff_seen)
                    begin
                        colon_seen_next = 1'b1;
                        colon_pos_next  = pos_reg;
                    end
                end
                pos_next = pos_inc;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LINE_START;
            pos_reg        <= '0;
            line_begin_reg <= '0;
            colon_pos_reg  <= '0;
            colon_seen_reg <= 1'b0;
            cont_reg       <= 1'b0;
            fc_reg         <= '0;
            last_voff_reg  <= '0;
            last_noff_reg  <= '0;
            last_nlen_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            line_begin_reg <= line_begin_next;
            colon_pos_reg  <= colon_pos_next;
            colon_seen_reg <= colon_seen_next;
            cont_reg       <= cont_next;
            fc_reg         <= fc_next;
            last_voff_reg  <= last_voff_next;
            last_noff_reg  <= last_noff_next;
            last_nlen_reg  <= last_nlen_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `HFLS_ASSERT_NXT(a_error_sticky, phase_reg == PH_ERROR, phase_reg == PH_ERROR,
                     "error phase left")
    `HFLS_ASSERT_IMP(a_error_event_phase, out_valid_reg && (out_reg.event_res == EV_ERROR),
                     phase_reg == PH_ERROR, "error reported without error phase")
    `HFLS_ASSERT_IMP(a_pos_bound, 1'b1, pos_reg <= PW'(MAX_BLOCK_BYTES),
                     "position beyond block limit")
    `HFLS_ASSERT_IMP(a_fc_bound, 1'b1, fc_reg <= CW'(MAX_FIELDS), "field count beyond limit")

endmodule

// ===== rtl/header_field_line_scanner.sv =====
// Header field line scanner: one event per header byte over stream ports.
// Each accepted byte's class is written into the queue, and its result then into the result register.
// Throughput: one byte per cycle while results are taken, set by the scanner update in the back end.
// A two-entry queue separates byte intake from the scanner; the result register holds
// a stalled result while the queue takes up to two more bytes. Reset (rst_n low, asynchronous)
// clears the queue, all scanner state and the result valid; no clearing pass is needed.
module header_field_line_scanner #(
    parameter int MAX_BLOCK_BYTES = hfls_pkg::DEF_MAX_BLOCK_BYTES,
    parameter int MAX_FIELDS      = hfls_pkg::DEF_MAX_FIELDS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] header_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // [2:0] event_res, [10:3] field_index,
                                        // [26:11] name_offset, [42:27] name_length,
                                        // [58:43] value_offset, [74:59] value_length,
                                        // [79:75] zero
);
    import hfls_pkg::*;

    logic         q_valid;
    hfls_class_t  q_class;
    logic         q_pop;
    hfls_result_t out_data;

    hfls_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .q_valid  (q_valid),
        .q_class  (q_class),
        .q_pop    (q_pop)
    );

    hfls_back #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
        .MAX_FIELDS      (MAX_FIELDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_class   (q_class),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    assign m_axis_tdata = out_data;

endmodule

// ===== test/tb_header_field_line_scanner.sv =====
// Self-checking bench for header_field_line_scanner: streams header bytes in and
// checks every event beat against a scanner predictor kept in this file or a typed table row.
// Depends on hfls_pkg and the RTL top; needs no files or arguments.
module tb_header_field_line_scanner;
    import hfls_pkg::*;

    localparam int unsigned MAX_BLOCK   = DEF_MAX_BLOCK_BYTES;
    localparam int unsigned MAX_FLD     = DEF_MAX_FIELDS;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          N_ROWS      = 28;

    typedef enum logic [1:0] {AT_LINE_START, IN_LINE, AFTER_CR, STUCK_ERROR} scan_phase_t;
    typedef enum bit {ROW_PREDICTED, ROW_TYPED} row_kind_t;
    typedef enum int {TAIL_BARE_CR, TAIL_NO_COLON, TAIL_ORPHAN,
                      TAIL_FIELD_OVERFLOW} tail_error_t;

    // Event column is only a note on predicted rows.
    typedef struct packed {
        logic [7:0] data;
        row_kind_t  kind;
        logic [2:0] ev;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] header_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;           // [2:0] event_res, [10:3] field_index,
                                         // [26:11] name_offset, [42:27] name_length,
                                         // [58:43] value_offset, [74:59] value_length,
                                         // [79:75] zero

    hfls_result_t expected_events [$];
    hfls_result_t got_res;
    hfls_result_t want_res;
    int           mismatches = 0;
    int           cycles = 0;
    int           bytes_sent = 0;
    int unsigned  tx_idle_pct = 0;
    int unsigned  rx_stall_pct = 0;
    int           hold_req = 0;
    int           hold_left = 0;
    int unsigned  tx_pct_by_phase [4] = '{0, 87, 0, 34};
    int unsigned  rx_pct_by_phase [4] = '{0, 0, 87, 34};

    // Scanner predictor state
    scan_phase_t  ph;
    int unsigned  pos;
    int unsigned  line_pos;
    int unsigned  colon_pos;
    bit           colon_found;
    bit           cont_line;
    int unsigned  n_fields;
    int unsigned  last_voff;
    int unsigned  last_noff;
    int unsigned  last_nlen;

    stim_row_t directed_rows [N_ROWS] = '{
        '{8'h41,      ROW_TYPED,     EV_READING},
        '{8'h00,      ROW_TYPED,     EV_READING},
        '{8'hFF,      ROW_TYPED,     EV_READING},
        '{CHAR_COLON, ROW_TYPED,     EV_READING},
        '{CHAR_COLON, ROW_TYPED,     EV_READING},   // second colon is a plain byte
        '{CHAR_CR,    ROW_TYPED,     EV_READING},
        '{CHAR_LF,    ROW_PREDICTED, EV_ADDED},
        '{CHAR_SPACE, ROW_TYPED,     EV_READING},
        '{CHAR_COLON, ROW_TYPED,     EV_READING},   // colon inside a continuation
        '{CHAR_LF,    ROW_TYPED,     EV_READING},   // bare LF inside a line
        '{CHAR_CR,    ROW_TYPED,     EV_READING},
        '{CHAR_LF,    ROW_PREDICTED, EV_EXTENDED},
        '{CHAR_LF,    ROW_TYPED,     EV_READING},   // LF opens a continuation
        '{CHAR_CR,    ROW_TYPED,     EV_READING},
        '{CHAR_LF,    ROW_PREDICTED, EV_EXTENDED},
        '{CHAR_HT,    ROW_TYPED,     EV_READING},
        '{CHAR_CR,    ROW_TYPED,     EV_READING},
        '{CHAR_LF,    ROW_PREDICTED, EV_EXTENDED},
        '{8'h08,      ROW_TYPED,     EV_READING},   // just below the whitespace range
        '{CHAR_COLON, ROW_TYPED,     EV_READING},
        '{CHAR_CR,    ROW_TYPED,     EV_READING},
        '{CHAR_LF,    ROW_PREDICTED, EV_ADDED},
        '{8'h0B,      ROW_TYPED,     EV_READING},
        '{8'h0C,      ROW_TYPED,     EV_READING},
        '{CHAR_CR,    ROW_TYPED,     EV_READING},
        '{CHAR_LF,    ROW_PREDICTED, EV_EXTENDED},
        '{CHAR_CR,    ROW_TYPED,     EV_READING},
        '{CHAR_LF,    ROW_TYPED,     EV_SEPARATOR}
    };

    header_field_line_scanner #(
        .MAX_BLOCK_BYTES(DEF_MAX_BLOCK_BYTES),
        .MAX_FIELDS     (DEF_MAX_FIELDS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic bit is_white(input logic [7:0] b);
        return b == CHAR_SPACE || (b >= CHAR_HT && b <= CHAR_CR);
    endfunction

    function automatic void clear_block();
        ph          = AT_LINE_START;
        pos         = 0;
        line_pos    = 0;
        colon_pos   = 0;
        colon_found = 1'b0;
        cont_line   = 1'b0;
        n_fields    = 0;
        last_voff   = 0;
        last_noff   = 0;
        last_nlen   = 0;
    endfunction

    function automatic hfls_result_t field_event(input logic [2:0] ev, input int unsigned idx,
                                                 input int unsigned vlen);
        hfls_result_t r;
        r              = '0;
        r.event_res    = ev;
        r.field_index  = 8'(idx);
        r.name_offset  = 16'(last_noff);
        r.name_length  = 16'(last_nlen);
        r.value_offset = 16'(last_voff);
        r.value_length = 16'(vlen);
        return r;
    endfunction

    // Advance the scanner by one byte and return the event it gives.
    function automatic hfls_result_t scan_byte(input logic [7:0] b);
        hfls_result_t r;
        int unsigned  p;
        r = '0;
        p = pos;
        if (ph == STUCK_ERROR || p >= MAX_BLOCK)
        begin
            ph = STUCK_ERROR;
            r.event_res = EV_ERROR;
            return r;
        end
        if (ph == AFTER_CR)
        begin
            if (b != CHAR_LF)
            begin
                ph = STUCK_ERROR;
                r.event_res = EV_ERROR;
                return r;
            end
            if (p - line_pos == 1)
            begin
                clear_block();
                r.event_res = EV_SEPARATOR;
                return r;
            end
            pos = p + 1;
            ph  = AT_LINE_START;
            if (cont_line)
            begin
                if (n_fields == 0)
                begin
                    ph = STUCK_ERROR;
                    r.event_res = EV_ERROR;
                    return r;
                end
                return field_event(EV_EXTENDED, n_fields - 1, p + 1 - last_voff);
            end
            if (!colon_found || n_fields >= MAX_FLD)
            begin
                ph = STUCK_ERROR;
                r.event_res = EV_ERROR;
                return r;
            end
            last_noff = line_pos;
            last_nlen = colon_pos - line_pos;
            last_voff = colon_pos + 1;
            n_fields++;
            return field_event(EV_ADDED, n_fields - 1, p + 1 - last_voff);
        end
        if (ph == AT_LINE_START)
        begin
            line_pos    = p;
            colon_found = 1'b0;
            colon_pos   = 0;
            cont_line   = is_white(b);
        end
        if (b == CHAR_CR)
            ph = AFTER_CR;
        else
        begin
            ph = IN_LINE;
            if (b == CHAR_COLON && !cont_line && !colon_found)
            begin
                colon_found = 1'b1;
                colon_pos   = p;
            end
        end
        pos = p + 1;
        return r;
    endfunction

    // Random byte that keeps a line open; optionally no colon and no leading whitespace.
    function automatic logic [7:0] pick_byte(input bit lead, input bit no_colon);
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == CHAR_CR || (no_colon && b == CHAR_COLON) || (lead && is_white(b)))
            b = 8'($urandom_range(255));
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input logic [2:0] typed_ev = EV_READING);
        hfls_result_t want;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        want = scan_byte(b);
        if (typed)
        begin
            want = '0;
            want.event_res = typed_ev;
        end
        expected_events.insert(expected_events.size(), want);
        bytes_sent++;
    endtask

    // One block of well-formed field and continuation lines, usually closed by a separator.
    task automatic send_block();
        int n_lines;
        int len;
        n_lines = $urandom_range(0, 6);
        for (int i = 0; i < n_lines; i++)
        begin
            if (n_fields != 0 && $urandom_range(3) == 0)
            begin
                if ($urandom_range(1) != 0)
                    send_byte(CHAR_SPACE);
                else
                    send_byte(8'($urandom_range(8'h09, 8'h0C)));
                len = $urandom_range(0, 6);
                for (int j = 0; j < len; j++)
                    send_byte(pick_byte(1'b0, 1'b0));
            end
            else
            begin
                len = $urandom_range(0, 5);
                for (int j = 0; j < len; j++)
                    send_byte(pick_byte(j == 0, 1'b1));
                send_byte(CHAR_COLON);
                len = $urandom_range(0, 8);
                for (int j = 0; j < len; j++)
                    send_byte(pick_byte(1'b0, 1'b0));
            end
            send_byte(CHAR_CR);
            send_byte(CHAR_LF);
        end
        // Force a separator before the field count or offset can run out.
        if ($urandom_range(4) != 0 || n_fields > 200 || pos > 60000)
        begin
            send_byte(CHAR_CR);
            send_byte(CHAR_LF);
        end
    endtask

    task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req <= 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Check each event beat against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_res = m_axis_tdata;
            if (expected_events.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got 0x%0h", $time, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want_res = expected_events.pop_front();
                cmp_field("event_res", 16'(want_res.event_res), 16'(got_res.event_res));
                cmp_field("field_index", 16'(want_res.field_index), 16'(got_res.field_index));
                cmp_field("name_offset", want_res.name_offset, got_res.name_offset);
                cmp_field("name_length", want_res.name_length, got_res.name_length);
                cmp_field("value_offset", want_res.value_offset, got_res.value_offset);
                cmp_field("value_length", want_res.value_length, got_res.value_length);
                cmp_field("pad", 16'(want_res.pad), 16'(got_res.pad));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL header_field_line_scanner");
            $finish;
        end
    end

    initial
    begin
        tail_error_t tail;
        int          target;
        int          per_phase;
        clear_block();
        // Errors stick until reset, so the run closes with one error kind picked at random.
        tail = tail_error_t'($urandom_range(3));
        // Field overflow alone takes about 770 bytes; shorten the random phases to match.
        per_phase = (tail == TAIL_FIELD_OVERFLOW) ? 130 : 315;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].kind == ROW_TYPED,
                      directed_rows[i].ev);

        for (int phase_no = 0; phase_no < 4; phase_no++)
        begin
            tx_idle_pct  = tx_pct_by_phase[phase_no];
            rx_stall_pct = rx_pct_by_phase[phase_no];
            // Hold the receiver off while bytes keep coming, to back the block up.
            if (phase_no == 0)
                hold_req <= 400;
            target = bytes_sent + per_phase;
            while (bytes_sent < target)
                send_block();
            if (phase_no == 1)
            begin
                s_axis_tvalid <= 1'b0;
                while (expected_events.size() != 0)
                    @(posedge clk);
            end
        end

        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        case (tail)
            TAIL_BARE_CR:
            begin
                send_byte(pick_byte(1'b1, 1'b0));
                send_byte(CHAR_CR);
                target = $urandom_range(255);
                while (target == CHAR_LF)
                    target = $urandom_range(255);
                send_byte(8'(target));
            end
            TAIL_NO_COLON:
            begin
                send_byte(pick_byte(1'b1, 1'b1));
                send_byte(pick_byte(1'b0, 1'b1));
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
            TAIL_ORPHAN:
            begin
                send_byte(CHAR_SPACE);
                send_byte(pick_byte(1'b0, 1'b0));
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
            default:
            begin
                // field overflow: one field line more than the block can hold
                repeat (MAX_FLD + 1)
                begin
                    send_byte(CHAR_COLON);
                    send_byte(CHAR_CR);
                    send_byte(CHAR_LF);
                end
            end
        endcase
        repeat (8)
            send_byte(8'($urandom_range(255)));
        s_axis_tvalid <= 1'b0;

        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("PASS header_field_line_scanner");
        else
            $display("FAIL header_field_line_scanner");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/hfls_pkg.sv
rtl/hfls_front.sv
rtl/hfls_back.sv
rtl/header_field_line_scanner.sv
test/tb_header_field_line_scanner.sv
